FILE: hdl/tccw_pkg.sv
// Package for the text console cursor writer.
// Holds action codes, character codes, register map and the item/result types.
// No dependencies.
package tccw_pkg;

  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;
  localparam int ENTRY_W   = 16;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int POS_W     = 8;

  localparam int TAB_STOP = 8;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam int PADDR_W = 3;
  localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [CHAR_W-1:0]  char_code;
    logic [POS_W-1:0]   new_column;
    logic [POS_W-1:0]   new_row;
  } item_t;

  typedef struct packed {
    logic                 write_valid;
    logic [OUT_COL_W-1:0] write_column;
    logic [OUT_ROW_W-1:0] write_row;
    logic [ENTRY_W-1:0]   write_entry;
    logic                 scroll_up;
    logic                 clear_all;
    logic [OUT_COL_W-1:0] cursor_column;
    logic [OUT_ROW_W-1:0] cursor_row;
  } result_t;

endpackage

FILE: hdl/tccw_step.sv
// Cursor update for one item: next cursor position and the result fields.
// Combinational; uses tccw_pkg.
module tccw_step
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int CW      = $clog2(COLUMNS),
  parameter int RW      = $clog2(ROWS)
) (
  input  item_t             item,
  input  logic [ATTR_W-1:0] attr,
  input  logic [CW-1:0]     cursor_x,
  input  logic [RW-1:0]     cursor_y,
  output logic [CW-1:0]     cursor_x_next,
  output logic [RW-1:0]     cursor_y_next,
  output result_t           res
);

  localparam logic [CW:0]   TAB_MASK  = (CW + 1)'(TAB_STOP - 1);
  localparam logic [CW:0]   COLS_W    = (CW + 1)'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [POS_W:0] COLS_POS = (POS_W + 1)'(COLUMNS);
  localparam logic [POS_W:0] ROWS_POS = (POS_W + 1)'(ROWS);

  logic [CW:0]          tab_x;
  logic [RW-1:0]        row_adv;
  logic                 row_wrap;
  logic                 set_ok;
  logic [CW-1:0]        x_new;
  logic [RW-1:0]        y_new;
  logic                 wv;
  logic [CW-1:0]        wc;
  logic [CHAR_W-1:0]    wch;
  logic                 scroll;
  logic                 clear;

  assign tab_x    = ({1'b0, cursor_x} | TAB_MASK) + (CW + 1)'(1);
  assign row_wrap = (cursor_y == LAST_ROW);
  assign row_adv  = row_wrap ? LAST_ROW : cursor_y + RW'(1);
  assign set_ok   = ({1'b0, item.new_column} < COLS_POS) && ({1'b0, item.new_row} < ROWS_POS);

  always_comb begin
    x_new  = cursor_x;
    y_new  = cursor_y;
    wv     = 1'b0;
    wc     = cursor_x;
    wch    = CH_SPACE;
    scroll = 1'b0;
    clear  = 1'b0;
    unique case (item.action)
      ACT_PUT: begin
        priority if (item.char_code == CH_LF) begin
          x_new  = '0;
          y_new  = row_adv;
          scroll = row_wrap;
        end else if (item.char_code == CH_CR) begin
          x_new = '0;
        end else if (item.char_code == CH_TAB) begin
          if (tab_x >= COLS_W) begin
            x_new  = '0;
            y_new  = row_adv;
            scroll = row_wrap;
          end else begin
            x_new = tab_x[CW-1:0];
          end
        end else if (item.char_code == CH_BS) begin
          if (cursor_x != '0) begin
            x_new = cursor_x - CW'(1);
            wv    = 1'b1;
            wc    = cursor_x - CW'(1);
          end
        end else begin
          wv  = 1'b1;
          wch = item.char_code;
          if (cursor_x == LAST_COL) begin
            x_new  = '0;
            y_new  = row_adv;
            scroll = row_wrap;
          end else begin
            x_new = cursor_x + CW'(1);
          end
        end
      end
      ACT_SET: begin
        x_new = set_ok ? item.new_column[CW-1:0] : '0;
        y_new = set_ok ? item.new_row[RW-1:0] : '0;
      end
      ACT_CLEAR: begin
        clear = 1'b1;
        x_new = '0;
        y_new = '0;
      end
      default: begin
      end
    endcase
  end

  assign cursor_x_next     = x_new;
  assign cursor_y_next     = y_new;
  assign res.write_valid   = wv;
  assign res.write_column  = wv ? OUT_COL_W'(wc) : '0;
  assign res.write_row     = wv ? OUT_ROW_W'(cursor_y) : '0;
  assign res.write_entry   = (wv || clear) ? {attr, wch} : '0;
  assign res.scroll_up     = scroll;
  assign res.clear_all     = clear;
  assign res.cursor_column = OUT_COL_W'(x_new);
  assign res.cursor_row    = OUT_ROW_W'(y_new);

endmodule

FILE: hdl/text_console_cursor_writer_top.sv
// Text console cursor writer: an accepted item is held in the input register, then its result in the result register.
// Throughput one item per cycle while the output is not stalled; input register, then result register.
// The input side keeps accepting while a result waits, until both registers hold.
// Synchronous reset: cursor to (0,0), text_attribute to 7, both registers empty.
// Uses tccw_pkg and tccw_step.
module text_console_cursor_writer_top
  import tccw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [23:0]        s_tdata,   // char_code, new_column, new_row
  input  logic [1:0]         s_tuser,   // action
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [39:0]        m_tdata,   // write_column, write_row, write_entry,
                                        // cursor_column, cursor_row
  output logic [2:0]         m_tuser,   // write_valid, scroll_up, clear_all
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  logic              in_valid;
  item_t             in_item;
  logic              out_valid;
  result_t           out_res;
  logic [CW-1:0]     cursor_x;
  logic [RW-1:0]     cursor_y;
  logic [CW-1:0]     cursor_x_next;
  logic [RW-1:0]     cursor_y_next;
  logic [ATTR_W-1:0] attr;
  result_t           step_res;
  logic              advance;
  logic              reg_sel;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign reg_sel  = (paddr[PADDR_W-1] == REG_TEXT_ATTRIBUTE);
  assign pready   = 1'b1;
  assign prdata   = reg_sel ? {24'd0, attr} : 32'd0;

  tccw_step #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_step (
    .item         (in_item),
    .attr         (attr),
    .cursor_x     (cursor_x),
    .cursor_y     (cursor_y),
    .cursor_x_next(cursor_x_next),
    .cursor_y_next(cursor_y_next),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      cursor_x  <= '0;
      cursor_y  <= '0;
      attr      <= ATTR_RESET;
    end else begin
      if (psel && penable && pwrite && pready && reg_sel) begin
        attr <= pwdata[ATTR_W-1:0];
      end
      if (advance) begin
        out_valid <= in_valid;
        if (in_valid) begin
          cursor_x <= cursor_x_next;
          cursor_y <= cursor_y_next;
        end
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.action     <= action_t'(s_tuser);
      in_item.char_code  <= s_tdata[7:0];
      in_item.new_column <= s_tdata[15:8];
      in_item.new_row    <= s_tdata[23:16];
    end
    if (advance && in_valid) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.cursor_row, out_res.cursor_column, out_res.write_entry,
                     out_res.write_row, out_res.write_column};
  assign m_tuser  = {out_res.clear_all, out_res.scroll_up, out_res.write_valid};

`ifndef NO_ASSERTIONS
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cursor_x} < (CW + 1)'(COLUMNS)) && ({1'b0, cursor_y} < (RW + 1)'(ROWS)))
    else $error("cursor outside the screen");

  a_clear_origin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.clear_all) |->
      (out_res.cursor_column == '0 && out_res.cursor_row == '0 && !out_res.write_valid))
    else $error("clear result without cursor at origin");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.scroll_up) |->
      (out_res.cursor_row == OUT_ROW_W'(ROWS - 1) && out_res.cursor_column == '0
       && !out_res.clear_all))
    else $error("scroll without cursor at start of last row");

  a_cursor_follows: assert property (@(posedge clk) disable iff (rst)
    (advance && in_valid) |=>
      (out_res.cursor_column == OUT_COL_W'(cursor_x)
       && out_res.cursor_row == OUT_ROW_W'(cursor_y)))
    else $error("reported cursor differs from cursor state");
`endif

endmodule
